[rtl/tse_pkg.sv]
// tse_pkg: shared types and constants for the take stream extractor
// no dependencies; used by the stream interfaces and the top level

package tse_pkg;

	localparam int HISTORY_DEPTH_DEFAULT = 32;

	localparam int BYTE_W    = 8;
	localparam int KIND_W    = 2;
	localparam int COUNT_W   = 17;
	localparam int SKIP_W    = 16;
	localparam int APB_DW    = 32;
	localparam int APB_AW    = 3;
	localparam int NAME_IDX_W = 5;

	localparam logic [SKIP_W-1:0] SKIP_RESET = 16'h5BBD;

	localparam logic [COUNT_W-1:0] GUARD_LEN     = 17'd5;
	localparam logic [COUNT_W-1:0] TAIL_LEN      = 17'd4;
	localparam logic [COUNT_W-1:0] BUFFER_LEN    = 17'd10;
	localparam logic [COUNT_W-1:0] DISCARD_EXTRA = 17'd6;

	// name burst: 12 song bytes, then 8 take bytes
	localparam logic [NAME_IDX_W-1:0] NAME_SONG_LEN = 5'd12;
	localparam logic [NAME_IDX_W-1:0] NAME_LAST_IDX = 5'd19;
	localparam logic [5:0]            SONG_TOP_POS  = 6'd30;
	localparam logic [5:0]            TAKE_TOP_POS  = 6'd20;

	localparam logic [BYTE_W-1:0] CH_T     = 8'h54;
	localparam logic [BYTE_W-1:0] CH_A     = 8'h41;
	localparam logic [BYTE_W-1:0] CH_K     = 8'h4B;
	localparam logic [BYTE_W-1:0] CH_E     = 8'h45;
	localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;

	localparam int END_MARK_LEN = 11;
	localparam logic [BYTE_W-1:0] END_MARK [END_MARK_LEN] = '{
		8'h56, 8'h53, 8'h31, 8'h36, 8'h38, 8'h30, 8'h45, 8'h54, 8'h32, 8'h35, 8'h44
	};

	localparam logic [KIND_W-1:0] KIND_NAME    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [KIND_W-1:0] KIND_END     = 2'd2;

	localparam logic [APB_AW-1:0] ADDR_SKIP = 3'd0;

	typedef enum logic [2:0] {
		MODE_GUARD,
		MODE_HUNT,
		MODE_TAIL,
		MODE_DISCARD,
		MODE_BUFFER,
		MODE_PAYLOAD
	} mode_t;

endpackage

[rtl/tse_byte_if.sv]
// tse_byte_if: valid/ready channel carrying one input byte
// depends on tse_pkg

interface tse_byte_if;
	logic                        valid;
	logic                        ready;
	logic [tse_pkg::BYTE_W-1:0]  data_byte;

	modport source (output valid, output data_byte, input ready);
	modport sink (input valid, input data_byte, output ready);
endinterface

[rtl/tse_result_if.sv]
// tse_result_if: valid/ready channel carrying one result item
// depends on tse_pkg

interface tse_result_if;
	logic                        valid;
	logic                        ready;
	logic [tse_pkg::KIND_W-1:0]  kind;
	logic [tse_pkg::BYTE_W-1:0]  value;
	logic                        last;

	modport source (output valid, output kind, output value, output last, input ready);
	modport sink (input valid, input kind, input value, input last, output ready);
endinterface

[rtl/take_stream_extractor_unit.sv]
// take_stream_extractor_unit: byte stream take extractor, top level
// depends on tse_pkg, tse_byte_if, tse_result_if
// a payload or end result sits in the output register in the cycle after its byte is accepted
// throughput: one byte per cycle while the output register is free and no name burst runs;
// the byte that ends the tail starts a 20-byte name burst that holds input until it ends,
// one name byte per cycle out of the output register while the result side does not stall
// reset: asynchronous, clears history to zeros, mode to guard (count 5), skip to 0x5BBD

module take_stream_extractor_unit #(
	parameter int HISTORY_DEPTH = tse_pkg::HISTORY_DEPTH_DEFAULT
) (
	input  logic                         clk,
	input  logic                         arst_n,
	tse_byte_if.sink                     stream,
	tse_result_if.source                 result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tse_pkg::APB_AW-1:0]   paddr,
	input  logic [tse_pkg::APB_DW-1:0]   pwdata,
	output logic [tse_pkg::APB_DW-1:0]   prdata,
	output logic                         pready
);

	localparam int HIST_W = $clog2(HISTORY_DEPTH);

	// history window, entry 0 is the newest byte
	logic [tse_pkg::BYTE_W-1:0]   history_q [HISTORY_DEPTH];
	tse_pkg::mode_t               mode_q, mode_d;
	logic [tse_pkg::COUNT_W-1:0]  count_q, count_d;
	logic [tse_pkg::SKIP_W-1:0]   skip_q;

	// name burst sequencer
	logic                             burst_q;
	logic [tse_pkg::NAME_IDX_W-1:0]   name_idx_q;

	// output register
	logic                         out_valid_q;
	logic [tse_pkg::KIND_W-1:0]   out_kind_q;
	logic [tse_pkg::BYTE_W-1:0]   out_value_q;
	logic                         out_last_q;

	logic                         out_free;
	logic                         accept;
	logic [tse_pkg::BYTE_W-1:0]   in_byte;
	logic                         hunt_hit;
	logic                         end_hit;
	logic                         count_done;
	logic                         burst_start;
	logic                         name_load;
	logic                         payload_load;
	logic [5:0]                   name_pos;
	logic [tse_pkg::BYTE_W-1:0]   name_byte;

	// ---------------------------------------------------------------
	// configuration port: single register, writes in the access phase
	// ---------------------------------------------------------------
	assign pready = 1'b1;

	always_comb begin
		prdata = '0;
		if (paddr == tse_pkg::ADDR_SKIP) begin
			prdata = {{(tse_pkg::APB_DW - tse_pkg::SKIP_W){1'b0}}, skip_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= tse_pkg::SKIP_RESET;
		end else if (psel && penable && pwrite && paddr == tse_pkg::ADDR_SKIP) begin
			skip_q <= pwdata[tse_pkg::SKIP_W-1:0];
		end
	end

	// ---------------------------------------------------------------
	// handshake: output register frees when empty or being drained,
	// input is held while the output register is not free or a name burst is in progress
	// ---------------------------------------------------------------
	assign out_free     = !out_valid_q || result.ready;
	assign stream.ready = !burst_q && out_free;
	assign accept       = stream.valid && stream.ready;
	assign in_byte      = stream.data_byte;

	assign count_done = (count_q <= tse_pkg::COUNT_W'(1));

	// "TAKE" sits in the four newest history bytes, incoming byte is not a space
	assign hunt_hit = history_q[3] == tse_pkg::CH_T && history_q[2] == tse_pkg::CH_A &&
		history_q[1] == tse_pkg::CH_K && history_q[0] == tse_pkg::CH_E &&
		in_byte != tse_pkg::CH_SPACE;

	// end marker over the ten newest stored bytes plus the incoming one
	always_comb begin
		end_hit = (in_byte == tse_pkg::END_MARK[tse_pkg::END_MARK_LEN-1]);
		for (int i = 0; i < tse_pkg::END_MARK_LEN - 1; i++) begin
			if (history_q[tse_pkg::END_MARK_LEN - 2 - i] != tse_pkg::END_MARK[i]) begin
				end_hit = 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// mode sequencer: next state
	// ---------------------------------------------------------------
	always_comb begin
		mode_d  = mode_q;
		count_d = count_q;
		if (accept) begin
			unique case (mode_q)
				tse_pkg::MODE_GUARD: begin
					if (!count_done) begin
						count_d = count_q - 1'b1;
					end else begin
						mode_d  = tse_pkg::MODE_HUNT;
						count_d = '0;
					end
				end
				tse_pkg::MODE_HUNT: begin
					if (hunt_hit) begin
						mode_d  = tse_pkg::MODE_TAIL;
						count_d = tse_pkg::TAIL_LEN;
					end
				end
				tse_pkg::MODE_TAIL: begin
					if (!count_done) begin
						count_d = count_q - 1'b1;
					end else begin
						mode_d  = tse_pkg::MODE_DISCARD;
						count_d = {1'b0, skip_q} + tse_pkg::DISCARD_EXTRA;
					end
				end
				tse_pkg::MODE_DISCARD: begin
					if (!count_done) begin
						count_d = count_q - 1'b1;
					end else begin
						mode_d  = tse_pkg::MODE_BUFFER;
						count_d = tse_pkg::BUFFER_LEN;
					end
				end
				tse_pkg::MODE_BUFFER: begin
					if (!count_done) begin
						count_d = count_q - 1'b1;
					end else begin
						mode_d  = tse_pkg::MODE_PAYLOAD;
						count_d = '0;
					end
				end
				tse_pkg::MODE_PAYLOAD: begin
					if (end_hit) begin
						mode_d  = tse_pkg::MODE_GUARD;
						count_d = tse_pkg::GUARD_LEN;
					end
				end
				default: begin
					mode_d  = tse_pkg::MODE_GUARD;
					count_d = tse_pkg::GUARD_LEN;
				end
			endcase
		end
	end

	// ---------------------------------------------------------------
	// mode sequencer: outputs (result loads and burst start)
	// ---------------------------------------------------------------
	always_comb begin
		burst_start  = 1'b0;
		payload_load = 1'b0;
		unique case (mode_q)
			tse_pkg::MODE_TAIL:    burst_start  = accept && count_done;
			tse_pkg::MODE_PAYLOAD: payload_load = accept;
			default: begin
				burst_start  = 1'b0;
				payload_load = 1'b0;
			end
		endcase
	end

	assign name_load = burst_q && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= tse_pkg::MODE_GUARD;
			count_q <= tse_pkg::GUARD_LEN;
		end else begin
			mode_q  <= mode_d;
			count_q <= count_d;
		end
	end

	// history shifts on every accepted byte except while discarding
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				history_q[i] <= '0;
			end
		end else if (accept && mode_q != tse_pkg::MODE_DISCARD) begin
			history_q[0] <= in_byte;
			for (int i = 1; i < HISTORY_DEPTH; i++) begin
				history_q[i] <= history_q[i-1];
			end
		end
	end

	// ---------------------------------------------------------------
	// name burst: history is frozen while input is held, so the name
	// bytes are read straight out of the window, while the output register is free one per cycle
	// ---------------------------------------------------------------
	always_comb begin
		if (name_idx_q < tse_pkg::NAME_SONG_LEN) begin
			name_pos = tse_pkg::SONG_TOP_POS - {1'b0, name_idx_q};
		end else begin
			name_pos = tse_pkg::TAKE_TOP_POS - {1'b0, name_idx_q};
		end
		name_byte = history_q[HIST_W'(name_pos)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			burst_q    <= 1'b0;
			name_idx_q <= '0;
		end else if (burst_start) begin
			burst_q    <= 1'b1;
			name_idx_q <= '0;
		end else if (name_load) begin
			name_idx_q <= name_idx_q + 1'b1;
			if (name_idx_q == tse_pkg::NAME_LAST_IDX) begin
				burst_q <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (name_load || payload_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (name_load) begin
			out_kind_q  <= tse_pkg::KIND_NAME;
			out_value_q <= name_byte;
			out_last_q  <= (name_idx_q == tse_pkg::NAME_LAST_IDX);
		end else if (payload_load) begin
			out_last_q <= 1'b1;
			if (end_hit) begin
				out_kind_q  <= tse_pkg::KIND_END;
				out_value_q <= '0;
			end else begin
				// byte eleven back once the incoming byte is pushed
				out_kind_q  <= tse_pkg::KIND_PAYLOAD;
				out_value_q <= history_q[tse_pkg::END_MARK_LEN - 2];
			end
		end
	end

	assign result.valid = out_valid_q;
	assign result.kind  = out_kind_q;
	assign result.value = out_value_q;
	assign result.last  = out_last_q;

endmodule

[bench/tb_take_stream_extractor_unit.sv]
// tb_take_stream_extractor_unit: self-checking bench for the take stream extractor
// depends on tse_pkg, tse_byte_if, tse_result_if and take_stream_extractor_unit
// a directed take from reset, then random takes over several skip settings, all scored

module tb_take_stream_extractor_unit;

	localparam int PERIOD        = 4;
	localparam int LIMIT_CYCLES  = 4_000_000;
	localparam int DRAIN_CYCLES  = 4;
	localparam int WINDOW        = tse_pkg::HISTORY_DEPTH_DEFAULT;
	localparam int RANDOM_ITEMS  = 380;
	localparam int NUM_PHASES    = 8;
	localparam int DIRECTED_ROWS = 33;
	// row at which the directed take has entered its discard stretch
	localparam int FIRST_DISCARD_ROW = 16;

	localparam logic [31:0] TAG_WORD  = "TAKE";
	localparam logic [7:0]  ASC_SPACE = " ";

	// own view of the block's timing
	localparam logic [tse_pkg::COUNT_W-1:0] GUARD_BYTES  = 17'd5;
	localparam logic [tse_pkg::COUNT_W-1:0] TAIL_BYTES   = 17'd4;
	localparam logic [tse_pkg::COUNT_W-1:0] BUFFER_BYTES = 17'd10;
	localparam logic [tse_pkg::COUNT_W-1:0] FIXED_SKIP   = 17'd6;
	localparam int SONG_BYTES = 12;
	localparam int SONG_FROM  = 31;
	localparam int TAKE_BYTES = 8;
	localparam int TAKE_FROM  = 9;
	localparam int PAYLOAD_AGO = 11;

	localparam logic [tse_pkg::SKIP_W-1:0] SKIP_AT_RESET = 16'h5BBD;
	localparam logic [tse_pkg::SKIP_W-1:0] SKIP_MAX      = 16'hFFFF;
	localparam logic [tse_pkg::APB_AW-1:0] ADDR_UNMAPPED = 3'd4;

	typedef struct packed {
		logic [tse_pkg::KIND_W-1:0] kind;
		logic [tse_pkg::BYTE_W-1:0] value;
		logic                       last;
	} take_result_t;

	typedef struct packed {
		logic [tse_pkg::BYTE_W-1:0] data_byte;
		logic                       pinned;
		take_result_t               res;
	} stim_row_t;

	localparam take_result_t NO_RESULT = '0;

	// directed take from reset: extremes in the guard, a take tag followed by a
	// space, a real tag, a name burst read from the early window, a discard
	// during which skip is rewritten, and an end marker right out of the buffer
	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{8'h00, 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT},
		'{"T", 1'b0, NO_RESULT}, '{"A", 1'b0, NO_RESULT}, '{"K", 1'b0, NO_RESULT},
		'{"E", 1'b0, NO_RESULT}, '{" ", 1'b0, NO_RESULT},
		'{"T", 1'b0, NO_RESULT}, '{"A", 1'b0, NO_RESULT}, '{"K", 1'b0, NO_RESULT},
		'{"E", 1'b0, NO_RESULT}, '{8'hFF, 1'b0, NO_RESULT},
		'{8'h00, 1'b0, NO_RESULT}, '{8'h7F, 1'b0, NO_RESULT}, '{8'h80, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, NO_RESULT},
		'{8'h55, 1'b0, NO_RESULT}, '{8'hAA, 1'b0, NO_RESULT}, '{8'h00, 1'b0, NO_RESULT},
		'{8'hFF, 1'b0, NO_RESULT}, '{tse_pkg::END_MARK[10], 1'b0, NO_RESULT},
		'{"T", 1'b0, NO_RESULT},
		'{tse_pkg::END_MARK[0], 1'b0, NO_RESULT}, '{tse_pkg::END_MARK[1], 1'b0, NO_RESULT},
		'{tse_pkg::END_MARK[2], 1'b0, NO_RESULT}, '{tse_pkg::END_MARK[3], 1'b0, NO_RESULT},
		'{tse_pkg::END_MARK[4], 1'b0, NO_RESULT}, '{tse_pkg::END_MARK[5], 1'b0, NO_RESULT},
		'{tse_pkg::END_MARK[6], 1'b0, NO_RESULT}, '{tse_pkg::END_MARK[7], 1'b0, NO_RESULT},
		'{tse_pkg::END_MARK[8], 1'b0, NO_RESULT}, '{tse_pkg::END_MARK[9], 1'b0, NO_RESULT},
		'{tse_pkg::END_MARK[10], 1'b1, '{tse_pkg::KIND_END, 8'h00, 1'b1}}
	};

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [tse_pkg::APB_AW-1:0] paddr;
	logic [tse_pkg::APB_DW-1:0] pwdata;
	logic [tse_pkg::APB_DW-1:0] prdata;
	logic                       pready;

	tse_byte_if   stream_ch ();
	tse_result_if result_ch ();

	take_stream_extractor_unit DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.stream  (stream_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// shadow of the extractor: byte window, mode, count and skip setting
	logic [tse_pkg::BYTE_W-1:0]  recent [WINDOW];
	tse_pkg::mode_t              track_mode;
	logic [tse_pkg::COUNT_W-1:0] track_count;
	logic [tse_pkg::SKIP_W-1:0]  skip_shadow;

	take_result_t step_results [$];
	take_result_t pending_results [$];
	take_result_t want;
	logic [tse_pkg::BYTE_W-1:0] plan [$];

	// a directed row may pin its result instead of taking the shadow's
	logic         pinned_now = 1'b0;
	take_result_t pinned_res = '0;
	logic         idle_on = 1'b1;
	int unsigned  fails = 0;

	always #(PERIOD / 2) clk = ~clk;

	// byte shifted in k bytes ago, 1 being the newest; discarded bytes are not stored
	function automatic logic [tse_pkg::BYTE_W-1:0] seen_ago(input int k);
		if (k < 1 || k > WINDOW)
			return '0;
		return recent[k - 1];
	endfunction

	function automatic void shift_in(input logic [tse_pkg::BYTE_W-1:0] b);
		for (int i = WINDOW - 1; i > 0; i--)
			recent[i] = recent[i - 1];
		recent[0] = b;
	endfunction

	// advance the shadow by one byte and collect the results it causes
	function automatic void take_byte(input logic [tse_pkg::BYTE_W-1:0] b);
		logic hit;
		step_results.delete();
		case (track_mode)
			tse_pkg::MODE_GUARD: begin
				shift_in(b);
				if (track_count > 1) begin
					track_count--;
				end else begin
					track_mode  = tse_pkg::MODE_HUNT;
					track_count = '0;
				end
			end
			tse_pkg::MODE_HUNT: begin
				shift_in(b);
				if ({seen_ago(5), seen_ago(4), seen_ago(3), seen_ago(2)} == TAG_WORD &&
						seen_ago(1) != ASC_SPACE) begin
					track_mode  = tse_pkg::MODE_TAIL;
					track_count = TAIL_BYTES;
				end
			end
			tse_pkg::MODE_TAIL: begin
				shift_in(b);
				if (track_count > 1) begin
					track_count--;
				end else begin
					// song name from deep in the window, then the take tag and its tail
					for (int i = 0; i < SONG_BYTES; i++)
						step_results.push_back(take_result_t'{tse_pkg::KIND_NAME,
							seen_ago(SONG_FROM - i), 1'b0});
					for (int i = 0; i < TAKE_BYTES; i++)
						step_results.push_back(take_result_t'{tse_pkg::KIND_NAME,
							seen_ago(TAKE_FROM - i), i == TAKE_BYTES - 1});
					track_mode  = tse_pkg::MODE_DISCARD;
					track_count = {1'b0, skip_shadow} + FIXED_SKIP;
				end
			end
			tse_pkg::MODE_DISCARD: begin
				if (track_count > 1) begin
					track_count--;
				end else begin
					track_mode  = tse_pkg::MODE_BUFFER;
					track_count = BUFFER_BYTES;
				end
			end
			tse_pkg::MODE_BUFFER: begin
				shift_in(b);
				if (track_count > 1) begin
					track_count--;
				end else begin
					track_mode  = tse_pkg::MODE_PAYLOAD;
					track_count = '0;
				end
			end
			tse_pkg::MODE_PAYLOAD: begin
				shift_in(b);
				hit = 1'b1;
				for (int i = 0; i < tse_pkg::END_MARK_LEN; i++)
					if (seen_ago(tse_pkg::END_MARK_LEN - i) != tse_pkg::END_MARK[i])
						hit = 1'b0;
				if (hit) begin
					step_results.push_back(take_result_t'{tse_pkg::KIND_END, 8'h00, 1'b1});
					track_mode  = tse_pkg::MODE_GUARD;
					track_count = GUARD_BYTES;
				end else begin
					step_results.push_back(take_result_t'{tse_pkg::KIND_PAYLOAD,
						seen_ago(PAYLOAD_AGO), 1'b1});
				end
			end
			default: begin
				shift_in(b);
				track_mode  = tse_pkg::MODE_GUARD;
				track_count = GUARD_BYTES;
			end
		endcase
	endfunction

	// next random byte: mostly well-formed takes with random content,
	// plus stray tag letters, space-broken tags and cut-off end markers
	function automatic logic [tse_pkg::BYTE_W-1:0] next_stream_byte();
		int n;
		int k;
		logic [tse_pkg::BYTE_W-1:0] c;
		if (plan.size() == 0) begin
			case (track_mode)
				tse_pkg::MODE_HUNT: begin
					n = $urandom_range(0, 6);
					repeat (n) begin
						if ($urandom_range(0, 1) == 0)
							plan.push_back(8'($urandom_range(0, 255)));
						else if ($urandom_range(0, 4) == 0)
							plan.push_back(ASC_SPACE);
						else
							plan.push_back(TAG_WORD[8 * $urandom_range(0, 3) +: 8]);
					end
					if ($urandom_range(0, 2) == 0) begin
						for (int i = 3; i >= 0; i--)
							plan.push_back(TAG_WORD[8 * i +: 8]);
						plan.push_back(ASC_SPACE);
					end
					for (int i = 3; i >= 0; i--)
						plan.push_back(TAG_WORD[8 * i +: 8]);
					do c = 8'($urandom_range(0, 255)); while (c == ASC_SPACE);
					plan.push_back(c);
				end
				tse_pkg::MODE_PAYLOAD: begin
					n = $urandom_range(0, 30);
					repeat (n) begin
						if ($urandom_range(0, 3) == 0)
							plan.push_back(tse_pkg::END_MARK[
								$urandom_range(0, tse_pkg::END_MARK_LEN - 1)]);
						else
							plan.push_back(8'($urandom_range(0, 255)));
					end
					if ($urandom_range(0, 3) == 0) begin
						k = $urandom_range(1, tse_pkg::END_MARK_LEN - 1);
						for (int i = 0; i < k; i++)
							plan.push_back(tse_pkg::END_MARK[i]);
						do c = 8'($urandom_range(0, 255)); while (c == tse_pkg::END_MARK[k]);
						plan.push_back(c);
					end
					for (int i = 0; i < tse_pkg::END_MARK_LEN; i++)
						plan.push_back(tse_pkg::END_MARK[i]);
				end
				default: begin
					return 8'($urandom_range(0, 255));
				end
			endcase
		end
		return plan.pop_front();
	endfunction

	// called at a falling edge; returns at the falling edge after acceptance
	task automatic send_byte(input logic [tse_pkg::BYTE_W-1:0] b, input logic pin,
			input take_result_t res);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			stream_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		pinned_now = pin;
		pinned_res = res;
		stream_ch.valid     <= 1'b1;
		stream_ch.data_byte <= b;
		do @(posedge clk); while (stream_ch.ready !== 1'b1);
		@(negedge clk);
	endtask

	// hold the sender until every result is in, then let the pipe settle
	task automatic wait_drained();
		stream_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [tse_pkg::APB_AW-1:0] addr,
			input logic [tse_pkg::APB_DW-1:0] data);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		if (addr == tse_pkg::ADDR_SKIP)
			skip_shadow = data[tse_pkg::SKIP_W-1:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic read_back_skip();
		logic [tse_pkg::APB_DW-1:0] got;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= tse_pkg::ADDR_SKIP;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		got = prdata;
		if (got !== {{(tse_pkg::APB_DW - tse_pkg::SKIP_W){1'b0}}, skip_shadow}) begin
			$error("skip_length: expected %0d, got %0d", skip_shadow, got);
			fails++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// scoreboard: shadow steps on each accepted byte, results are matched in order
	always @(posedge clk) begin
		if (arst_n === 1'b1) begin
			if (stream_ch.valid === 1'b1 && stream_ch.ready === 1'b1) begin
				take_byte(stream_ch.data_byte);
				if (pinned_now)
					pending_results.push_back(pinned_res);
				else
					foreach (step_results[i])
						pending_results.push_back(step_results[i]);
			end
			if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
				if (pending_results.size() == 0) begin
					$error("result transaction with nothing pending: kind %0d value %0h last %0b",
						result_ch.kind, result_ch.value, result_ch.last);
					fails++;
				end else begin
					want = pending_results.pop_front();
					if (result_ch.kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, result_ch.kind);
						fails++;
					end
					if (result_ch.value !== want.value) begin
						$error("value: expected %0h, got %0h", want.value, result_ch.value);
						fails++;
					end
					if (result_ch.last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, result_ch.last);
						fails++;
					end
				end
			end
		end
	end

	// receiver: random stall bursts while idling is on, otherwise always ready
	initial begin
		result_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end
			result_ch.ready <= 1'b1;
		end
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		logic [tse_pkg::SKIP_W-1:0] settings [NUM_PHASES];
		logic [tse_pkg::BYTE_W-1:0] b;
		int unsigned counted;
		int unsigned goal;

		// known values on every input, shadow at its reset state
		arst_n              = 1'b0;
		stream_ch.valid     = 1'b0;
		stream_ch.data_byte = '0;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		foreach (recent[i])
			recent[i] = '0;
		track_mode  = tse_pkg::MODE_GUARD;
		track_count = GUARD_BYTES;
		skip_shadow = SKIP_AT_RESET;
		counted     = 0;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset value, masking of the upper data bits, write to an unmapped address
		read_back_skip();
		write_reg(tse_pkg::ADDR_SKIP, 32'hFFFF_0000);
		read_back_skip();
		write_reg(ADDR_UNMAPPED, 32'h0000_1234);
		read_back_skip();

		// directed take; skip is rewritten to its maximum while discarding and
		// must not change the count already loaded
		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			if (r == FIRST_DISCARD_ROW) begin
				wait_drained();
				write_reg(tse_pkg::ADDR_SKIP, {16'h0000, SKIP_MAX});
				read_back_skip();
			end
			send_byte(DIRECTED[r].data_byte, DIRECTED[r].pinned, DIRECTED[r].res);
		end

		// random takes, one skip setting per phase, each change made while idle
		settings = '{16'd1, 16'd40, 16'd0, 16'($urandom_range(0, 40)), 16'd2, 16'd9,
			16'($urandom_range(0, 40)), 16'd5};
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			write_reg(tse_pkg::ADDR_SKIP, {16'($urandom), settings[p]});
			read_back_skip();
			idle_on = (p == NUM_PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
			goal = (RANDOM_ITEMS * (p + 1)) / NUM_PHASES;
			while (counted < goal) begin
				b = next_stream_byte();
				counted++;
				send_byte(b, 1'b0, NO_RESULT);
			end
		end

		wait_drained();
		if (fails == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule

[take_stream_extractor_unit.f]
rtl/tse_pkg.sv
rtl/tse_byte_if.sv
rtl/tse_result_if.sv
rtl/take_stream_extractor_unit.sv
bench/tb_take_stream_extractor_unit.sv
